// ===== rtl/double_ended_array_store_unit_defines.svh =====
// Assertion macros used by the checker file of the double-ended store.
`ifndef DOUBLE_ENDED_ARRAY_STORE_UNIT_DEFINES_SVH
`define DOUBLE_ENDED_ARRAY_STORE_UNIT_DEFINES_SVH

// Clocked assertion that is switched off while reset is high.
`define DEAS_ASSERT(lbl, ck, rs, prop, msg) \
  lbl: assert property (@(posedge ck) disable iff (rs) prop) else $error(msg);

// Clocked assertion that also holds while reset is high.
`define DEAS_ASSERT_ALWAYS(lbl, ck, prop, msg) \
  lbl: assert property (@(posedge ck) prop) else $error(msg);

`endif

// ===== rtl/deas_pkg.sv =====
// ----------------------------------------------------------------------------
// deas_pkg
// Types, codes and defaults shared by the double-ended ring store.
// ----------------------------------------------------------------------------
package deas_pkg;

  localparam int DEPTH_DEFAULT         = 16;
  localparam int ELEMENT_WIDTH_DEFAULT = 32;

  localparam int CMD_W   = 3;
  localparam int DATA_W  = 32;
  localparam int INDEX_W = 4;
  localparam int COUNT_W = 5;
  localparam int ERR_W   = 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_READ       = 3'd4
  } command_t;

  typedef enum logic [ERR_W-1:0] {
    ERR_OK    = 2'd0,
    ERR_EMPTY = 2'd1,
    ERR_FULL  = 2'd2,
    ERR_RANGE = 2'd3
  } error_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic execute;
    logic load_out;
  } ctrl_cmd_t;

endpackage

// ===== rtl/deas_ifs.sv =====
// ----------------------------------------------------------------------------
// deas_ifs
// Valid/ready channels for commands into and results out of the store.
// ----------------------------------------------------------------------------
interface deas_req_if;
  logic                         valid;
  logic                         ready;
  logic [deas_pkg::CMD_W-1:0]   command;
  logic [deas_pkg::DATA_W-1:0]  element_data;
  logic [deas_pkg::INDEX_W-1:0] item_index;

  modport source (output valid, output command, output element_data,
                  output item_index, input ready);
  modport sink   (input valid, input command, input element_data,
                  input item_index, output ready);
endinterface

interface deas_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [deas_pkg::DATA_W-1:0]  read_data;
  logic [deas_pkg::COUNT_W-1:0] entry_count;
  logic                         is_empty;
  logic [deas_pkg::ERR_W-1:0]   error_code;

  modport source (output valid, output read_data, output entry_count,
                  output is_empty, output error_code, input ready);
  modport sink   (input valid, input read_data, input entry_count,
                  input is_empty, input error_code, output ready);
endinterface

// ===== rtl/deas_ctrl.sv =====
// ----------------------------------------------------------------------------
// deas_ctrl
// Sequencer: capture a command, run its memory access, hand over the result.
// ----------------------------------------------------------------------------
module deas_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  output logic                out_valid,
  input  logic                out_ready,
  output deas_pkg::ctrl_cmd_t cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RESULT
  } state_t;

  state_t state;
  logic   out_free;

  assign in_ready     = (state == S_IDLE);
  assign out_free     = !out_valid || out_ready;
  assign cmd.capture  = in_valid && in_ready;
  assign cmd.execute  = (state == S_EXEC);
  assign cmd.load_out = (state == S_RESULT) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) state <= S_EXEC;
        end
        S_EXEC: begin
          state <= S_RESULT;
        end
        S_RESULT: begin
          // Wait here until the result register is free or being emptied.
          if (out_free) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (cmd.load_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

// ===== rtl/deas_datapath.sv =====
// ----------------------------------------------------------------------------
// deas_datapath
// Ring pointers, element memory and result register of the store.
// ----------------------------------------------------------------------------
module deas_datapath #(
  parameter int DEPTH         = deas_pkg::DEPTH_DEFAULT,
  parameter int ELEMENT_WIDTH = deas_pkg::ELEMENT_WIDTH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  deas_pkg::ctrl_cmd_t          cmd,
  input  logic [deas_pkg::CMD_W-1:0]   command,
  input  logic [deas_pkg::DATA_W-1:0]  element_data,
  input  logic [deas_pkg::INDEX_W-1:0] item_index,
  output logic [deas_pkg::DATA_W-1:0]  read_data,
  output logic [deas_pkg::COUNT_W-1:0] entry_count,
  output logic                         is_empty,
  output logic [deas_pkg::ERR_W-1:0]   error_code
);

  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = PTR_W + 2;
  localparam int CMP_W = (CNT_W > deas_pkg::INDEX_W) ? CNT_W : deas_pkg::INDEX_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

  logic [ELEMENT_WIDTH-1:0] mem [DEPTH];
  logic [ELEMENT_WIDTH-1:0] mem_rdata;

  logic [PTR_W-1:0]             front;
  logic [CNT_W-1:0]             count;
  logic [deas_pkg::CMD_W-1:0]   cmd_q;
  logic [ELEMENT_WIDTH-1:0]     data_q;
  logic [deas_pkg::INDEX_W-1:0] idx_q;
  deas_pkg::error_t             err_q;
  logic                         rd_valid_q;

  logic [PTR_W-1:0]   front_next;
  logic [CNT_W-1:0]   count_next;
  deas_pkg::error_t   err_next;
  logic               rd_valid_next;
  logic               we;
  logic [PTR_W-1:0]   addr;
  logic [CNT_W-1:0]   offset;
  logic [SUM_W-1:0]   sum;
  logic [PTR_W-1:0]   slot;
  logic [PTR_W-1:0]   front_dec;
  logic [PTR_W-1:0]   front_inc;
  logic               is_full;
  logic               is_zero;
  logic               in_range;

  assign is_full  = (count == FULL_COUNT);
  assign is_zero  = (count == '0);
  assign in_range = CMP_W'(idx_q) < CMP_W'(count);

  assign front_dec = (front == '0) ? LAST_SLOT : front - 1'b1;
  assign front_inc = (front == LAST_SLOT) ? '0 : front + 1'b1;

  // Logical offset from the front of the slot this command touches.
  always_comb begin
    case (cmd_q)
      deas_pkg::CMD_PUSH_BACK: offset = count;
      deas_pkg::CMD_POP_BACK:  offset = count - 1'b1;
      deas_pkg::CMD_READ:      offset = CNT_W'(idx_q);
      default:                 offset = '0;
    endcase
  end

  // For a command that succeeds the sum stays below twice the depth, so one conditional subtract wraps it.
  assign sum  = SUM_W'(front) + SUM_W'(offset);
  assign slot = (sum >= DEPTH_SUM) ? PTR_W'(sum - DEPTH_SUM) : PTR_W'(sum);

  always_comb begin
    front_next    = front;
    count_next    = count;
    err_next      = deas_pkg::ERR_OK;
    rd_valid_next = 1'b0;
    we            = 1'b0;
    addr          = slot;
    unique case (cmd_q)
      deas_pkg::CMD_PUSH_FRONT: begin
        addr = front_dec;
        if (is_full) begin
          err_next = deas_pkg::ERR_FULL;
        end else begin
          we         = 1'b1;
          front_next = front_dec;
          count_next = count + 1'b1;
        end
      end
      deas_pkg::CMD_PUSH_BACK: begin
        if (is_full) begin
          err_next = deas_pkg::ERR_FULL;
        end else begin
          we         = 1'b1;
          count_next = count + 1'b1;
        end
      end
      deas_pkg::CMD_POP_FRONT: begin
        addr = front;
        if (is_zero) begin
          err_next = deas_pkg::ERR_EMPTY;
        end else begin
          rd_valid_next = 1'b1;
          front_next    = front_inc;
          count_next    = count - 1'b1;
        end
      end
      deas_pkg::CMD_POP_BACK: begin
        if (is_zero) begin
          err_next = deas_pkg::ERR_EMPTY;
        end else begin
          rd_valid_next = 1'b1;
          count_next    = count - 1'b1;
        end
      end
      deas_pkg::CMD_READ: begin
        if (!in_range) begin
          err_next = deas_pkg::ERR_RANGE;
        end else begin
          rd_valid_next = 1'b1;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      front <= '0;
      count <= '0;
    end else if (cmd.execute) begin
      front <= front_next;
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_q  <= command;
      data_q <= ELEMENT_WIDTH'(element_data);
      idx_q  <= item_index;
    end
    if (cmd.execute) begin
      err_q      <= err_next;
      rd_valid_q <= rd_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.execute && we) mem[addr] <= data_q;
    if (cmd.execute) mem_rdata <= mem[addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      read_data   <= rd_valid_q ? deas_pkg::DATA_W'(mem_rdata) : '0;
      entry_count <= deas_pkg::COUNT_W'(count);
      is_empty    <= (count == '0);
      error_code  <= err_q;
    end
  end

endmodule

// ===== rtl/double_ended_array_store_unit.sv =====
// ----------------------------------------------------------------------------
// double_ended_array_store_unit
// Double-ended ring store: push and pop at either end, read by index.
//
//   Channel    Role   Carries
//   request    sink   command, element_data, item_index
//   response   source read_data, entry_count, is_empty, error_code
//
// A command is captured at its transfer, then runs its access of the single-port
// element memory (registered read), then loads the result register once that
// register is free. One command is worked at a time, so a new command is taken
// only after the last one has loaded its result.
// Reset clears the front pointer and count; entries stay undefined until pushed,
// so there is no clearing pass. While a result waits in its register, the next
// command is still taken and held at its result cycle until the register frees.
// ----------------------------------------------------------------------------
module double_ended_array_store_unit #(
  parameter int DEPTH         = deas_pkg::DEPTH_DEFAULT,
  parameter int ELEMENT_WIDTH = deas_pkg::ELEMENT_WIDTH_DEFAULT
) (
  input logic        clk,
  input logic        rst,
  deas_req_if.sink   request,
  deas_rsp_if.source response
);

  deas_pkg::ctrl_cmd_t cmd;

  deas_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (request.valid),
    .in_ready  (request.ready),
    .out_valid (response.valid),
    .out_ready (response.ready),
    .cmd       (cmd)
  );

  deas_datapath #(
    .DEPTH         (DEPTH),
    .ELEMENT_WIDTH (ELEMENT_WIDTH)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .command      (request.command),
    .element_data (request.element_data),
    .item_index   (request.item_index),
    .read_data    (response.read_data),
    .entry_count  (response.entry_count),
    .is_empty     (response.is_empty),
    .error_code   (response.error_code)
  );

endmodule

// ===== rtl/deas_checker.sv =====
// ----------------------------------------------------------------------------
// deas_checker
// Port-level checks on the double-ended store, bound to its top level.
// ----------------------------------------------------------------------------
`include "double_ended_array_store_unit_defines.svh"

module deas_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         req_valid,
  input logic                         req_ready,
  input logic                         rsp_valid,
  input logic                         rsp_ready,
  input logic [deas_pkg::DATA_W-1:0]  read_data,
  input logic [deas_pkg::COUNT_W-1:0] entry_count,
  input logic                         is_empty,
  input logic [deas_pkg::ERR_W-1:0]   error_code
);

  // A stalled result keeps its contents.
  `DEAS_ASSERT(a_rsp_hold, clk, rst, rsp_valid && !rsp_ready |=> rsp_valid && $stable(read_data) && $stable(entry_count) && $stable(is_empty) && $stable(error_code), "response changed while stalled")

  // Commands are worked one at a time, so a transfer is never followed at once.
  `DEAS_ASSERT(a_one_at_a_time, clk, rst, req_valid && req_ready |=> !req_ready, "request taken in back-to-back cycles")

  // A failed command never returns data.
  `DEAS_ASSERT(a_err_no_data, clk, rst, rsp_valid && error_code != deas_pkg::ERR_OK |-> read_data == '0, "data returned with an error")

  `DEAS_ASSERT(a_empty_count, clk, rst, rsp_valid && is_empty |-> entry_count == '0, "empty flag with nonzero count")

  `DEAS_ASSERT_ALWAYS(a_reset_quiet, clk, rst |=> !rsp_valid, "response valid after reset")

endmodule

bind double_ended_array_store_unit deas_checker u_deas_checker (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (request.valid),
  .req_ready   (request.ready),
  .rsp_valid   (response.valid),
  .rsp_ready   (response.ready),
  .read_data   (response.read_data),
  .entry_count (response.entry_count),
  .is_empty    (response.is_empty),
  .error_code  (response.error_code)
);

// ===== tb/double_ended_array_store_unit_check.sv =====
// ----------------------------------------------------------------------------
// double_ended_array_store_unit_check
// Watches the command and result channels of the double-ended ring store,
// keeps its own copy of the ring, works out the result of every command
// that transfers, and compares each result transfer with the oldest one
// still awaited.
// ----------------------------------------------------------------------------
module double_ended_array_store_unit_check
  import deas_pkg::*;
#(
  parameter int DEPTH         = DEPTH_DEFAULT,
  parameter int ELEMENT_WIDTH = ELEMENT_WIDTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst,
  deas_req_if         request,
  deas_rsp_if         response,
  output int unsigned fail_count,
  output int unsigned pending_results,
  output int unsigned stored_elements
);

  typedef struct packed {
    logic [DATA_W-1:0]  read_data;
    logic [COUNT_W-1:0] entry_count;
    logic               is_empty;
    logic [ERR_W-1:0]   error_code;
  } deque_result_t;

  logic [ELEMENT_WIDTH-1:0] ring [DEPTH];
  int unsigned              front_slot;
  int unsigned              fill;
  deque_result_t            awaited_results [$];

  function automatic int unsigned slot_of(int unsigned offset);
    return (front_slot + offset) % DEPTH;
  endfunction

  // Applies one command to the shadow ring and returns the result it owes.
  function automatic deque_result_t apply_command(logic [CMD_W-1:0] cmd,
                                                  logic [DATA_W-1:0] data,
                                                  logic [INDEX_W-1:0] idx);
    deque_result_t res;
    res.read_data  = '0;
    res.error_code = ERR_OK;
    case (cmd)
      CMD_PUSH_FRONT: begin
        if (fill == DEPTH) begin
          res.error_code = ERR_FULL;
        end else begin
          front_slot = (front_slot + DEPTH - 1) % DEPTH;
          ring[front_slot] = ELEMENT_WIDTH'(data);
          fill++;
        end
      end
      CMD_PUSH_BACK: begin
        if (fill == DEPTH) begin
          res.error_code = ERR_FULL;
        end else begin
          ring[slot_of(fill)] = ELEMENT_WIDTH'(data);
          fill++;
        end
      end
      CMD_POP_FRONT: begin
        if (fill == 0) begin
          res.error_code = ERR_EMPTY;
        end else begin
          res.read_data = DATA_W'(ring[front_slot]);
          front_slot = slot_of(1);
          fill--;
        end
      end
      CMD_POP_BACK: begin
        if (fill == 0) begin
          res.error_code = ERR_EMPTY;
        end else begin
          res.read_data = DATA_W'(ring[slot_of(fill - 1)]);
          fill--;
        end
      end
      CMD_READ: begin
        if (idx >= fill) begin
          res.error_code = ERR_RANGE;
        end else begin
          res.read_data = DATA_W'(ring[slot_of(idx)]);
        end
      end
      default: begin
        // Spare command codes leave the store untouched.
      end
    endcase
    res.entry_count = COUNT_W'(fill);
    res.is_empty    = (fill == 0);
    return res;
  endfunction

  task automatic compare_field(string name, logic [DATA_W-1:0] want,
                               logic [DATA_W-1:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin
    deque_result_t want;
    if (rst) begin
      front_slot = 0;
      fill       = 0;
      awaited_results.delete();
    end else begin
      if (response.valid && response.ready) begin
        if (awaited_results.size() == 0) begin
          $error("result transfer with no command outstanding");
          fail_count++;
        end else begin
          want = awaited_results.pop_front();
          compare_field("read_data", want.read_data, response.read_data);
          compare_field("entry_count", DATA_W'(want.entry_count),
                        DATA_W'(response.entry_count));
          compare_field("is_empty", DATA_W'(want.is_empty), DATA_W'(response.is_empty));
          compare_field("error_code", DATA_W'(want.error_code),
                        DATA_W'(response.error_code));
        end
      end
      if (request.valid && request.ready) begin
        awaited_results.push_back(apply_command(request.command, request.element_data,
                                                request.item_index));
      end
    end
    pending_results <= awaited_results.size();
    stored_elements <= fill;
  end

endmodule

// ===== tb/double_ended_array_store_unit_test.sv =====
// ----------------------------------------------------------------------------
// double_ended_array_store_unit_test
// Drives commands into the double-ended ring store: a directed opening over
// the empty and full corners, spare codes and index limits, then phases of
// random commands that lean toward filling, draining or neither, with random
// gaps on the command side and random stalls on the result side.
// ----------------------------------------------------------------------------
module double_ended_array_store_unit_test;
  import deas_pkg::*;

  localparam int DEPTH           = DEPTH_DEFAULT;
  localparam int ELEMENT_WIDTH   = ELEMENT_WIDTH_DEFAULT;
  localparam int RANDOM_COMMANDS = 1700;
  localparam int CYCLE_LIMIT     = 500000;
  localparam int DRAIN_CYCLES    = 8;

  localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
  localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  int unsigned fail_count;
  int unsigned pending_results;
  int unsigned stored_elements;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit          send_quiet = 1'b0;
  bit          take_quiet = 1'b0;

  deas_req_if request ();
  deas_rsp_if response ();

  double_ended_array_store_unit #(
    .DEPTH        (DEPTH),
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
  ) dut (
    .clk     (clk),
    .rst     (rst),
    .request (request),
    .response(response)
  );

  double_ended_array_store_unit_check #(
    .DEPTH        (DEPTH),
    .ELEMENT_WIDTH(ELEMENT_WIDTH)
  ) check_unit (
    .clk            (clk),
    .rst            (rst),
    .request        (request),
    .response       (response),
    .fail_count     (fail_count),
    .pending_results(pending_results),
    .stored_elements(stored_elements)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[double_ended_array_store_unit] ERROR");
      $finish;
    end
  end

  // Mostly short pauses, now and then a long one.
  function automatic int unsigned pick_delay(bit quiet);
    int unsigned r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  always @(posedge clk) begin
    if (stall_left != 0) begin
      response.ready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!take_quiet && $urandom_range(0, 99) < 30) begin
      response.ready <= 1'b0;
      stall_left <= pick_delay(1'b0);
    end else begin
      response.ready <= 1'b1;
    end
  end

  // Returns at the edge of the transfer with valid still high, so that a
  // following command without a gap keeps valid up.
  task automatic send_command(logic [CMD_W-1:0] cmd, logic [DATA_W-1:0] data,
                              logic [INDEX_W-1:0] idx);
    int unsigned gap;
    gap = pick_delay(send_quiet);
    if (gap != 0) begin
      request.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    request.valid        <= 1'b1;
    request.command      <= cmd;
    request.element_data <= data;
    request.item_index   <= idx;
    @(posedge clk);
    while (!request.ready) @(posedge clk);
  endtask

  task automatic send_random(int unsigned push_bias);
    int unsigned        r;
    logic [CMD_W-1:0]   cmd;
    logic [INDEX_W-1:0] idx;
    r = $urandom_range(0, 99);
    if (r < 2) begin
      cmd = CMD_W'($urandom_range(CMD_SPARE_FIRST, CMD_SPARE_LAST));
    end else if (r < 22) begin
      cmd = CMD_READ;
    end else if ($urandom_range(0, 99) < push_bias) begin
      cmd = $urandom_range(0, 1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT;
    end else begin
      cmd = $urandom_range(0, 1) ? CMD_POP_BACK : CMD_POP_FRONT;
    end
    // Reads mostly land on stored elements; the rest probe the whole range.
    if (stored_elements != 0 && $urandom_range(0, 3) != 0) begin
      idx = INDEX_W'($urandom_range(0, stored_elements - 1));
    end else begin
      idx = INDEX_W'($urandom);
    end
    send_command(cmd, $urandom, idx);
  endtask

  initial begin
    int unsigned k;
    int unsigned sent;
    int unsigned phase;
    int unsigned length;
    int unsigned push_bias;
    request.valid        <= 1'b0;
    request.command      <= CMD_PUSH_FRONT;
    request.element_data <= '0;
    request.item_index   <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Empty store: both pops and a read are refused; spare codes do nothing.
    send_command(CMD_POP_FRONT, '0, '0);
    send_command(CMD_POP_BACK, '1, '1);
    send_command(CMD_READ, '0, '0);
    for (k = CMD_SPARE_FIRST; k <= CMD_SPARE_LAST; k++) begin
      send_command(CMD_W'(k), $urandom, INDEX_W'($urandom));
    end
    // Push at the front wraps the front pointer below slot zero.
    send_command(CMD_PUSH_FRONT, '1, '0);
    send_command(CMD_PUSH_BACK, '0, '0);
    send_command(CMD_READ, '0, 4'd1);
    send_command(CMD_READ, '0, '1);
    for (k = 2; k < DEPTH; k++) begin
      send_command(k[0] ? CMD_PUSH_BACK : CMD_PUSH_FRONT, $urandom, '0);
    end
    // Full store: pushes at either end are refused, the last index is valid.
    send_command(CMD_PUSH_FRONT, $urandom, '0);
    send_command(CMD_PUSH_BACK, $urandom, '0);
    send_command(CMD_READ, '0, '1);
    send_command(CMD_POP_FRONT, '0, '0);
    send_command(CMD_POP_BACK, '0, '0);

    sent  = 0;
    phase = 0;
    while (sent < RANDOM_COMMANDS) begin
      length = $urandom_range(30, 120);
      case (phase % 3)
        0: begin
          push_bias = 80;
        end
        1: begin
          push_bias = 20;
        end
        default: begin
          push_bias = 50;
        end
      endcase
      send_quiet = (phase % 5 == 4);
      take_quiet = (phase % 7 == 3);
      repeat (length) send_random(push_bias);
      sent += length;
      // Hold the command side until every result is out.
      if (phase % 6 == 2) begin
        request.valid <= 1'b0;
        do @(posedge clk); while (pending_results != 0);
      end
      phase++;
    end

    request.valid <= 1'b0;
    do @(posedge clk); while (pending_results != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && pending_results == 0) begin
      $display("[double_ended_array_store_unit] OK");
    end else begin
      $display("[double_ended_array_store_unit] ERROR");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/deas_pkg.sv
rtl/deas_ifs.sv
rtl/deas_ctrl.sv
rtl/deas_datapath.sv
rtl/double_ended_array_store_unit.sv
rtl/deas_checker.sv
tb/double_ended_array_store_unit_check.sv
tb/double_ended_array_store_unit_test.sv
